// File: rtl/cdas_pkg.sv
// shared types, constants and calendar helpers for the date add/subtract block
`default_nettype none
package cdas_pkg;

  localparam int YearBits  = 14;
  localparam int MonthBits = 4;
  localparam int DayBits   = 5;
  localparam int InDayBits = 16;
  localparam int RemBits   = 9;
  localparam int CountBitsDefault = 16;

  localparam logic [YearBits-1:0]  YearMin  = 14'd1900;
  localparam logic [YearBits-1:0]  YearMax  = 14'd9999;
  localparam logic [MonthBits-1:0] MonthJan = 4'd1;
  localparam logic [MonthBits-1:0] MonthDec = 4'd12;
  localparam logic [DayBits-1:0]   DayFirst = 5'd1;

  // year modulo the 400 year leap cycle
  localparam int LeapCycle = 400;
  localparam logic [RemBits:0]   CycleWide = (RemBits+1)'(LeapCycle);
  localparam logic [RemBits-1:0] RemLast   = RemBits'(LeapCycle - 1);
  localparam logic [RemBits-1:0] RemReset  = RemBits'(1900 % LeapCycle);

  typedef enum logic [1:0] {
    OP_SET = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2,
    OP_CMP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ORD_EQUAL   = 2'd0,
    ORD_LATER   = 2'd1,
    ORD_EARLIER = 2'd2
  } order_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_DATE = 2'd1,
    STAT_RANGE    = 2'd2
  } status_t;

  typedef struct packed {
    logic [YearBits-1:0]  year;
    logic [MonthBits-1:0] month;
    logic [DayBits-1:0]   day;
    logic [RemBits-1:0]   m400;
  } date_t;

  typedef struct packed {
    logic start;
    logic sub;
  } walk_cmd_t;

  typedef struct packed {
    logic done;
    logic range_err;
  } walk_stat_t;

  // leap test from the year's remainder modulo 400
  function automatic logic leap_of(input logic [RemBits-1:0] r);
    logic by4;
    logic century;
    by4     = (r[1:0] == 2'd0);
    century = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
    return (by4 && !century) || (r == '0);
  endfunction

  // month length, zero for a month number outside 1..12
  function automatic logic [DayBits-1:0] days_in_month(input logic [MonthBits-1:0] m,
                                                       input logic leap);
    logic [DayBits-1:0] d;
    d = '0;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:                                       d = leap ? 5'd29 : 5'd28;
      default:                                    d = '0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// File: rtl/cdas_rem400.sv
// remainder of a year modulo 400 by reciprocal multiplication, registered once
`default_nettype none
module cdas_rem400 (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [cdas_pkg::YearBits-1:0] value,
  output logic                               done,
  output logic [cdas_pkg::RemBits-1:0]       rem
);

  // 400 = 16 * 25: the low four bits pass straight through, the rest go modulo 25
  localparam int LowBits   = 4;
  localparam int HiBits    = cdas_pkg::YearBits - LowBits;
  localparam int ResBits   = cdas_pkg::RemBits - LowBits;
  localparam int QBits     = 6;
  localparam int ProdBits  = HiBits + QBits;
  // 41 / 1024 stands in for 1 / 25, exact for every high part below 1024
  localparam int RecipBits = 10;
  localparam logic [QBits-1:0]   Recip25 = 6'd41;
  localparam logic [ResBits-1:0] Mod25   = 5'd25;

  logic                          done_r, done_nxt;
  logic [cdas_pkg::RemBits-1:0]  rem_r, rem_nxt;
  logic [HiBits-1:0]             hi;
  logic [ProdBits-1:0]           prod;
  logic [QBits-1:0]              quo;
  logic [HiBits-1:0]             quo25;
  logic [ResBits-1:0]            hi_rem;

  always_comb begin
    hi       = value[cdas_pkg::YearBits-1:LowBits];
    prod     = ProdBits'(hi) * ProdBits'(Recip25);
    quo      = QBits'(prod >> RecipBits);
    quo25    = HiBits'(quo) * HiBits'(Mod25);
    hi_rem   = ResBits'(hi - quo25);
    done_nxt = start;
    rem_nxt  = rem_r;
    if (start) begin
      rem_nxt = {hi_rem, value[LowBits-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// File: rtl/cdas_walk.sv
// month-by-month walker for adding or subtracting a day count
`default_nettype none
module cdas_walk #(
  parameter int COUNT_BITS = cdas_pkg::CountBitsDefault
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cdas_pkg::walk_cmd_t   cmd,
  input  wire cdas_pkg::date_t       start_date,
  input  wire logic [COUNT_BITS-1:0] count,
  output cdas_pkg::walk_stat_t       stat,
  output cdas_pkg::date_t            date_o
);

  logic                  busy_r, busy_nxt;
  logic                  sub_r, sub_nxt;
  logic                  done_r, done_nxt;
  logic                  err_r, err_nxt;
  cdas_pkg::date_t       date_r, date_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;

  logic                          leap;
  logic [cdas_pkg::DayBits-1:0]  dim;
  logic [cdas_pkg::DayBits-1:0]  room;
  logic [COUNT_BITS-1:0]         room_ext;
  logic [COUNT_BITS-1:0]         day_ext;
  cdas_pkg::date_t               adv;
  cdas_pkg::date_t               prv;
  logic                          at_top;
  logic                          at_bottom;

  always_comb begin
    leap     = cdas_pkg::leap_of(date_r.m400);
    dim      = cdas_pkg::days_in_month(date_r.month, leap);
    room     = dim - date_r.day;
    room_ext = COUNT_BITS'(room);
    day_ext  = COUNT_BITS'(date_r.day);

    // first day of the next month
    adv     = date_r;
    adv.day = cdas_pkg::DayFirst;
    if (date_r.month == cdas_pkg::MonthDec) begin
      adv.month = cdas_pkg::MonthJan;
      adv.year  = date_r.year + 1'b1;
      adv.m400  = (date_r.m400 == cdas_pkg::RemLast) ? '0 : date_r.m400 + 1'b1;
    end else begin
      adv.month = date_r.month + 1'b1;
    end

    // last day of the previous month
    prv = date_r;
    if (date_r.month == cdas_pkg::MonthJan) begin
      prv.month = cdas_pkg::MonthDec;
      prv.year  = date_r.year - 1'b1;
      prv.m400  = (date_r.m400 == '0) ? cdas_pkg::RemLast : date_r.m400 - 1'b1;
    end else begin
      prv.month = date_r.month - 1'b1;
    end
    prv.day = cdas_pkg::days_in_month(prv.month, cdas_pkg::leap_of(prv.m400));

    at_top    = (date_r.year == cdas_pkg::YearMax) && (date_r.month == cdas_pkg::MonthDec);
    at_bottom = (date_r.year == cdas_pkg::YearMin) && (date_r.month == cdas_pkg::MonthJan);

    busy_nxt = busy_r;
    sub_nxt  = sub_r;
    done_nxt = 1'b0;
    err_nxt  = 1'b0;
    date_nxt = date_r;
    cnt_nxt  = cnt_r;

    if (cmd.start) begin
      busy_nxt = 1'b1;
      sub_nxt  = cmd.sub;
      date_nxt = start_date;
      cnt_nxt  = count;
    end else if (busy_r) begin
      if (!sub_r) begin
        if (cnt_r <= room_ext) begin
          date_nxt.day = date_r.day + cnt_r[cdas_pkg::DayBits-1:0];
          busy_nxt     = 1'b0;
          done_nxt     = 1'b1;
        end else if (at_top) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
          err_nxt  = 1'b1;
        end else begin
          cnt_nxt  = cnt_r - room_ext - 1'b1;
          date_nxt = adv;
        end
      end else begin
        if (cnt_r < day_ext) begin
          date_nxt.day = date_r.day - cnt_r[cdas_pkg::DayBits-1:0];
          busy_nxt     = 1'b0;
          done_nxt     = 1'b1;
        end else if (at_bottom) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
          err_nxt  = 1'b1;
        end else begin
          cnt_nxt  = cnt_r - day_ext;
          date_nxt = prv;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      err_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      err_r  <= err_nxt;
    end
    sub_r  <= sub_nxt;
    date_r <= date_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign stat.done      = done_r;
  assign stat.range_err = err_r;
  assign date_o         = date_r;

endmodule
`default_nettype wire

// File: rtl/calendar_date_add_subtract.sv
// top level of the Gregorian date register with add, subtract and compare
`default_nettype none
// Holds one Gregorian date (1900-01-01 after reset) and serves one request at
// a time: set, add days, subtract days, compare. Every request gives exactly
// one result carrying the held date afterwards, the compare order and a
// status. Compare goes straight to the result; set first waits for the
// registered modulo-400 remainder of the new year that drives the leap rule
// and then checks the date; add and subtract run the walker, which moves one
// calendar month per cycle. A finished result that finds the output register
// still stalled waits for it. in_ready is high only while no request is in
// flight, but a finished result may sit in the output register while the
// next request is already accepted.
module calendar_date_add_subtract #(
  parameter int COUNT_BITS = cdas_pkg::CountBitsDefault
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_op,
  input  wire logic [cdas_pkg::YearBits-1:0]  in_year_in,
  input  wire logic [cdas_pkg::MonthBits-1:0] in_month_in,
  input  wire logic [cdas_pkg::InDayBits-1:0] in_day_in,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [cdas_pkg::YearBits-1:0]       out_year_out,
  output logic [cdas_pkg::MonthBits-1:0]      out_month_out,
  output logic [cdas_pkg::DayBits-1:0]        out_day_out,
  output logic [1:0]                          out_order,
  output logic [1:0]                          out_status
);

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_REM  = 4'b0010,
    S_WALK = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // held date, with its year modulo 400 kept alongside for the leap rule
  cdas_pkg::date_t cur_r, cur_nxt;

  // result waiting to be committed and presented
  cdas_pkg::date_t   pend_r, pend_nxt;
  cdas_pkg::order_t  pord_r, pord_nxt;
  cdas_pkg::status_t pstat_r, pstat_nxt;

  // set request fields kept while the remainder unit runs
  logic [cdas_pkg::YearBits-1:0]  yi_r, yi_nxt;
  logic [cdas_pkg::MonthBits-1:0] mi_r, mi_nxt;
  logic [cdas_pkg::InDayBits-1:0] di_r, di_nxt;

  // output register
  logic                           ovld_r, ovld_nxt;
  cdas_pkg::date_t                odate_r, odate_nxt;
  cdas_pkg::order_t               oord_r, oord_nxt;
  cdas_pkg::status_t              ostat_r, ostat_nxt;

  logic                           accept;
  logic                           load_out;
  cdas_pkg::op_t                  op;

  logic                           rem_start;
  logic                           rem_done;
  logic [cdas_pkg::RemBits-1:0]   rem;

  cdas_pkg::walk_cmd_t            wcmd;
  cdas_pkg::walk_stat_t           wstat;
  cdas_pkg::date_t                wdate;

  logic [cdas_pkg::DayBits-1:0]   set_dim;
  logic                           set_ok;
  cdas_pkg::order_t               cmp_ord;

  assign op       = cdas_pkg::op_t'(in_op);
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  // result can move into the output register when it is empty or draining
  assign load_out = (state_r == S_DONE) && (!ovld_r || out_ready);

  assign rem_start  = accept && (op == cdas_pkg::OP_SET);
  assign wcmd.start = accept && ((op == cdas_pkg::OP_ADD) || (op == cdas_pkg::OP_SUB));
  assign wcmd.sub   = (op == cdas_pkg::OP_SUB);

  cdas_rem400 u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rem_start),
    .value (in_year_in),
    .done  (rem_done),
    .rem   (rem)
  );

  cdas_walk #(
    .COUNT_BITS (COUNT_BITS)
  ) u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (wcmd),
    .start_date (cur_r),
    .count      (COUNT_BITS'(in_day_in)),
    .stat       (wstat),
    .date_o     (wdate)
  );

  // set validity once the year's leap position is known
  always_comb begin
    set_dim = cdas_pkg::days_in_month(mi_r, cdas_pkg::leap_of(rem));
    set_ok  = (yi_r >= cdas_pkg::YearMin) && (yi_r <= cdas_pkg::YearMax) &&
              (set_dim != '0) && (di_r != '0) &&
              (di_r <= cdas_pkg::InDayBits'(set_dim));
  end

  // raw field compare: year, then month, then day
  always_comb begin
    if (cur_r.year != in_year_in) begin
      cmp_ord = (cur_r.year > in_year_in) ? cdas_pkg::ORD_LATER : cdas_pkg::ORD_EARLIER;
    end else if (cur_r.month != in_month_in) begin
      cmp_ord = (cur_r.month > in_month_in) ? cdas_pkg::ORD_LATER : cdas_pkg::ORD_EARLIER;
    end else if (cdas_pkg::InDayBits'(cur_r.day) != in_day_in) begin
      cmp_ord = (cdas_pkg::InDayBits'(cur_r.day) > in_day_in) ?
                cdas_pkg::ORD_LATER : cdas_pkg::ORD_EARLIER;
    end else begin
      cmp_ord = cdas_pkg::ORD_EQUAL;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    pend_nxt  = pend_r;
    pord_nxt  = pord_r;
    pstat_nxt = pstat_r;
    yi_nxt    = yi_r;
    mi_nxt    = mi_r;
    di_nxt    = di_r;
    ovld_nxt  = ovld_r && !out_ready;
    odate_nxt = odate_r;
    oord_nxt  = oord_r;
    ostat_nxt = ostat_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          yi_nxt    = in_year_in;
          mi_nxt    = in_month_in;
          di_nxt    = in_day_in;
          pend_nxt  = cur_r;
          pord_nxt  = cdas_pkg::ORD_EQUAL;
          pstat_nxt = cdas_pkg::STAT_OK;
          unique case (op)
            cdas_pkg::OP_SET: state_nxt = S_REM;
            cdas_pkg::OP_ADD,
            cdas_pkg::OP_SUB: state_nxt = S_WALK;
            cdas_pkg::OP_CMP: begin
              pord_nxt  = cmp_ord;
              state_nxt = S_DONE;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_REM: begin
        if (rem_done) begin
          if (set_ok) begin
            pend_nxt.year  = yi_r;
            pend_nxt.month = mi_r;
            pend_nxt.day   = di_r[cdas_pkg::DayBits-1:0];
            pend_nxt.m400  = rem;
          end else begin
            pstat_nxt = cdas_pkg::STAT_BAD_DATE;
          end
          state_nxt = S_DONE;
        end
      end
      S_WALK: begin
        if (wstat.done) begin
          // out-of-range walk leaves the held date as it was
          if (wstat.range_err) begin
            pstat_nxt = cdas_pkg::STAT_RANGE;
          end else begin
            pend_nxt = wdate;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          cur_nxt   = pend_r;
          ovld_nxt  = 1'b1;
          odate_nxt = pend_r;
          oord_nxt  = pord_r;
          ostat_nxt = pstat_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      ovld_r        <= 1'b0;
      cur_r.year    <= cdas_pkg::YearMin;
      cur_r.month   <= cdas_pkg::MonthJan;
      cur_r.day     <= cdas_pkg::DayFirst;
      cur_r.m400    <= cdas_pkg::RemReset;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
      cur_r   <= cur_nxt;
    end
    pend_r  <= pend_nxt;
    pord_r  <= pord_nxt;
    pstat_r <= pstat_nxt;
    yi_r    <= yi_nxt;
    mi_r    <= mi_nxt;
    di_r    <= di_nxt;
    odate_r <= odate_nxt;
    oord_r  <= oord_nxt;
    ostat_r <= ostat_nxt;
  end

  assign out_valid     = ovld_r;
  assign out_year_out  = odate_r.year;
  assign out_month_out = odate_r.month;
  assign out_day_out   = odate_r.day;
  assign out_order     = oord_r;
  assign out_status    = ostat_r;

endmodule
`default_nettype wire

// File: rtl/cdas_check.sv
// port-level checker for the date block, bound to the top level
`default_nettype none
module cdas_check (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [cdas_pkg::YearBits-1:0]  out_year_out,
  input wire logic [cdas_pkg::MonthBits-1:0] out_month_out,
  input wire logic [cdas_pkg::DayBits-1:0]   out_day_out,
  input wire logic [1:0]                     out_order,
  input wire logic [1:0]                     out_status
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_year_out) &&
    $stable(out_month_out) && $stable(out_day_out) && $stable(out_order) &&
    $stable(out_status))
    else $error("result changed while stalled");

  // one request in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  // held date is always a date in range
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_year_out >= cdas_pkg::YearMin && out_year_out <= cdas_pkg::YearMax &&
    out_month_out >= cdas_pkg::MonthJan && out_month_out <= cdas_pkg::MonthDec &&
    out_day_out >= cdas_pkg::DayFirst)
    else $error("held date out of range");

  // an ordering only comes with a clean compare
  a_order_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_order != cdas_pkg::ORD_EQUAL |-> out_status == cdas_pkg::STAT_OK)
    else $error("order given with error status");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind calendar_date_add_subtract cdas_check u_cdas_check (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_year_out  (out_year_out),
  .out_month_out (out_month_out),
  .out_day_out   (out_day_out),
  .out_order     (out_order),
  .out_status    (out_status)
);
`default_nettype wire

// File: verif/calendar_date_add_subtract_checker.sv
// result checker: follows the request and result channels and predicts each held date
`timescale 1ns / 1ps
module calendar_date_add_subtract_checker #(
  parameter int COUNT_BITS = cdas_pkg::CountBitsDefault
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire logic [1:0]                     in_op,
  input  wire logic [cdas_pkg::YearBits-1:0]  in_year_in,
  input  wire logic [cdas_pkg::MonthBits-1:0] in_month_in,
  input  wire logic [cdas_pkg::InDayBits-1:0] in_day_in,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire logic [cdas_pkg::YearBits-1:0]  out_year_out,
  input  wire logic [cdas_pkg::MonthBits-1:0] out_month_out,
  input  wire logic [cdas_pkg::DayBits-1:0]   out_day_out,
  input  wire logic [1:0]                     out_order,
  input  wire logic [1:0]                     out_status,
  output int                                  fail_count,
  output int                                  pending_count
);
  import cdas_pkg::*;

  localparam int FirstYear  = int'(YearMin);
  localparam int LastYear   = int'(YearMax);
  localparam int FirstMonth = int'(MonthJan);
  localparam int LastMonth  = int'(MonthDec);
  localparam int FirstDay   = int'(DayFirst);

  typedef struct {
    logic [YearBits-1:0]  year;
    logic [MonthBits-1:0] month;
    logic [DayBits-1:0]   day;
    order_t               order;
    status_t              status;
  } date_result_t;

  date_result_t due_results[$];
  int held_year  = FirstYear;
  int held_month = FirstMonth;
  int held_day   = FirstDay;
  int mismatches = 0;
  int waiting    = 0;

  assign fail_count    = mismatches;
  assign pending_count = waiting;

  function automatic bit leap_year(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_days(input int y, input int m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic int leaps_through(input int x);
    return x / 4 - x / 100 + x / 400;
  endfunction

  // days from the first supported new year to 1 january of y
  function automatic int days_to_year(input int y);
    return 365 * (y - FirstYear) + leaps_through(y - 1) - leaps_through(FirstYear - 1);
  endfunction

  function automatic int day_number(input int y, input int m, input int d);
    int n;
    n = days_to_year(y);
    for (int k = FirstMonth; k < m; k++) n += month_days(y, k);
    return n + d - 1;
  endfunction

  function automatic void hold_day_number(input int n);
    int y;
    int m;
    y = FirstYear + n / 366;
    while (days_to_year(y + 1) <= n) y++;
    n -= days_to_year(y);
    m = FirstMonth;
    while (n >= month_days(y, m)) begin
      n -= month_days(y, m);
      m++;
    end
    held_year  = y;
    held_month = m;
    held_day   = n + 1;
  endfunction

  // applies one request to the held date and returns the result it should give
  function automatic date_result_t apply_request(input op_t op, input int yi, input int mi,
                                                 input int di);
    date_result_t r;
    longint count;
    longint n;
    count    = longint'(di) & ((longint'(1) << COUNT_BITS) - 1);
    r.order  = ORD_EQUAL;
    r.status = STAT_OK;
    case (op)
      OP_SET: begin
        if (yi >= FirstYear && yi <= LastYear && mi >= FirstMonth && mi <= LastMonth &&
            di >= FirstDay && di <= month_days(yi, mi)) begin
          held_year  = yi;
          held_month = mi;
          held_day   = di;
        end else begin
          r.status = STAT_BAD_DATE;
        end
      end
      OP_ADD: begin
        n = day_number(held_year, held_month, held_day) + count;
        if (n > day_number(LastYear, LastMonth, 31)) r.status = STAT_RANGE;
        else hold_day_number(int'(n));
      end
      OP_SUB: begin
        n = day_number(held_year, held_month, held_day);
        if (count > n) r.status = STAT_RANGE;
        else hold_day_number(int'(n - count));
      end
      default: begin
        if (held_year != yi) r.order = (held_year > yi) ? ORD_LATER : ORD_EARLIER;
        else if (held_month != mi) r.order = (held_month > mi) ? ORD_LATER : ORD_EARLIER;
        else if (held_day != di) r.order = (held_day > di) ? ORD_LATER : ORD_EARLIER;
      end
    endcase
    r.year  = YearBits'(held_year);
    r.month = MonthBits'(held_month);
    r.day   = DayBits'(held_day);
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    date_result_t want;
    if (!rst_n) begin
      held_year  = FirstYear;
      held_month = FirstMonth;
      held_day   = FirstDay;
      due_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result with no request waiting: %0d-%0d-%0d", out_year_out,
                 out_month_out, out_day_out);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("year_out", want.year, out_year_out);
          check_field("month_out", want.month, out_month_out);
          check_field("day_out", want.day, out_day_out);
          check_field("order", want.order, out_order);
          check_field("status", want.status, out_status);
        end
      end
      if (in_valid && in_ready)
        due_results.push_back(apply_request(op_t'(in_op), in_year_in, in_month_in, in_day_in));
    end
    waiting = due_results.size();
  end

endmodule

// File: verif/calendar_date_add_subtract_tb.sv
// testbench top: clock, reset, request stimulus, result back-pressure and verdict
`timescale 1ns / 1ps
module calendar_date_add_subtract_tb;
  import cdas_pkg::*;

  localparam int CountBits      = CountBitsDefault;
  localparam int RandomRequests = 245;
  // watchdog bound on the whole run, covering the longest walks plus stalls and gaps
  localparam int CycleLimit     = 3_000_000;
  // quiet spell after the last expected result, to catch stray results
  localparam int DrainCycles    = 60;

  // receiver back-pressure patterns, swapped periodically by the result side
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_HALF,
    STALL_HEAVY,
    STALL_PULSE
  } stall_t;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_op       = OP_SET;
  logic [YearBits-1:0]  in_year_in  = '0;
  logic [MonthBits-1:0] in_month_in = '0;
  logic [InDayBits-1:0] in_day_in   = '0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic [YearBits-1:0]  out_year_out;
  logic [MonthBits-1:0] out_month_out;
  logic [DayBits-1:0]   out_day_out;
  logic [1:0]           out_order;
  logic [1:0]           out_status;

  int     fail_count;
  int     pending_count;
  int     cycle_count = 0;
  int     burst_left  = 0;
  int     issued      = 0;
  stall_t stall_mode  = STALL_NONE;

  always #1 clk = ~clk;

  calendar_date_add_subtract #(
    .COUNT_BITS(CountBits)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_year_in   (in_year_in),
    .in_month_in  (in_month_in),
    .in_day_in    (in_day_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_year_out (out_year_out),
    .out_month_out(out_month_out),
    .out_day_out  (out_day_out),
    .out_order    (out_order),
    .out_status   (out_status)
  );

  calendar_date_add_subtract_checker #(
    .COUNT_BITS(CountBits)
  ) date_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_year_in   (in_year_in),
    .in_month_in  (in_month_in),
    .in_day_in    (in_day_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_year_out (out_year_out),
    .out_month_out(out_month_out),
    .out_day_out  (out_day_out),
    .out_order    (out_order),
    .out_status   (out_status),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  // result side: a new pattern is drawn periodically so stalls land on every phase,
  // with whole stretches of no stall at all
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 97 == 0) stall_mode <= stall_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:  out_ready <= 1'b1;
      STALL_HALF:  out_ready <= 1'($urandom_range(0, 1));
      STALL_HEAVY: out_ready <= ($urandom_range(0, 4) == 0);
      default:     out_ready <= cycle_count[2];
    endcase
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_count >= CycleLimit) begin
      $display("calendar_date_add_subtract_tb: done, errors");
      $finish;
    end
  end

  // presents one request and holds it until the block takes it; between bursts
  // valid drops for a random gap, within a burst the next request follows at once
  task automatic issue_request(input op_t op, input int y, input int m, input int d);
    in_valid    <= 1'b1;
    in_op       <= op;
    in_year_in  <= YearBits'(y);
    in_month_in <= MonthBits'(m);
    in_day_in   <= InDayBits'(d);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    issued++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end else begin
      burst_left--;
    end
  endtask

  // day counts: mostly short walks, a few reaching the full count width
  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 400);
    if (r < 95) return $urandom_range(0, 5000);
    return $urandom_range(0, 65535);
  endfunction

  // mostly safe days, sometimes the month end (which may be out of range)
  function automatic int pick_day();
    return ($urandom_range(0, 3) != 0) ? $urandom_range(1, 28) : $urandom_range(29, 31);
  endfunction

  // small offset so compares land on equal and on each neighbour
  function automatic int nudge();
    int r;
    r = $urandom_range(0, 4);
    if (r < 3) return 0;
    return (r == 3) ? 1 : -1;
  endfunction

  initial begin
    int kind;
    int y;
    int m;
    int d;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    issue_request(OP_CMP, 1900, 1, 1);        // reset date compares equal
    issue_request(OP_SUB, 0, 0, 1);           // borrow below the first supported day
    issue_request(OP_ADD, 0, 0, 0);           // zero count leaves the date alone
    issue_request(OP_SET, 1900, 2, 29);       // 1900 is not a leap year
    issue_request(OP_SET, 2000, 2, 29);       // but 2000 is
    issue_request(OP_ADD, 0, 0, 1);           // carry into march
    issue_request(OP_SUB, 0, 0, 1);           // borrow back to the leap day
    issue_request(OP_SET, 2001, 1, 15);
    issue_request(OP_SUB, 0, 0, 20);          // borrow out of january into last december
    issue_request(OP_SET, 9999, 12, 31);
    issue_request(OP_ADD, 0, 0, 1);           // past the last supported day
    issue_request(OP_CMP, 9999, 12, 31);
    issue_request(OP_CMP, 16383, 15, 65535);  // raw compare, all fields at their top
    issue_request(OP_CMP, 0, 0, 0);           // raw compare, all fields at zero
    issue_request(OP_SET, 1899, 6, 1);        // year below range
    issue_request(OP_SET, 10000, 1, 1);       // year above range
    issue_request(OP_SET, 2024, 0, 1);        // month zero
    issue_request(OP_SET, 2024, 13, 1);       // month above december
    issue_request(OP_SET, 2024, 4, 31);       // day beyond a 30 day month
    issue_request(OP_SET, 2024, 1, 0);        // day zero
    issue_request(OP_SET, 2024, 1, 65535);    // day far out of range
    issue_request(OP_SET, 1900, 1, 1);
    issue_request(OP_ADD, 0, 0, 65535);       // longest walk forward
    issue_request(OP_CMP, 2079, 6, 7);        // same year and month, day differs
    issue_request(OP_SUB, 0, 0, 65535);       // longest walk back, lands on the first day
    issue_request(OP_SUB, 0, 0, 65535);       // and again, now out of range

    // --- random part ---
    issued = 0;
    while (issued < RandomRequests) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        // year and month are ignored here, so they carry noise
        issue_request(OP_ADD, $urandom_range(0, 16383), $urandom_range(0, 15), pick_count());
      end else if (kind < 55) begin
        issue_request(OP_SUB, $urandom_range(0, 16383), $urandom_range(0, 15), pick_count());
      end else if (kind < 70) begin
        // set a date, then compare against it or a close neighbour
        y = $urandom_range(1900, 9999);
        m = $urandom_range(1, 12);
        d = pick_day();
        issue_request(OP_SET, y, m, d);
        issue_request(OP_CMP, y + nudge(), m + nudge(), d + nudge());
      end else if (kind < 80) begin
        // park near an end of the range and walk towards it
        if ($urandom_range(0, 1)) begin
          issue_request(OP_SET, $urandom_range(9990, 9999), $urandom_range(1, 12), pick_day());
          issue_request(OP_ADD, 0, 0, $urandom_range(0, 4000));
        end else begin
          issue_request(OP_SET, $urandom_range(1900, 1909), $urandom_range(1, 12), pick_day());
          issue_request(OP_SUB, 0, 0, $urandom_range(0, 4000));
        end
      end else if (kind < 90) begin
        // broken set requests, one bad field at a time; the long-day case may still hit a valid day
        case ($urandom_range(0, 4))
          0: issue_request(OP_SET, $urandom_range(0, 1899), 1, 1);
          1: issue_request(OP_SET, $urandom_range(10000, 16383), 1, 1);
          2: issue_request(OP_SET, 2000, ($urandom_range(0, 1) ? 0 : $urandom_range(13, 15)), 1);
          3: issue_request(OP_SET, $urandom_range(1900, 9999), $urandom_range(1, 12), 0);
          default: issue_request(OP_SET, $urandom_range(1900, 9999), $urandom_range(1, 12),
                                 $urandom_range(29, 65535));
        endcase
      end else begin
        issue_request(OP_CMP, $urandom_range(0, 16383), $urandom_range(0, 15),
                      $urandom_range(0, 65535));
      end
    end

    @(posedge clk);
    in_valid <= 1'b0;

    // drain: every expected result back, then a quiet spell for stray results
    while (pending_count != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0) begin
      $display("calendar_date_add_subtract_tb: done, clean");
    end else begin
      $display("calendar_date_add_subtract_tb: done, errors");
    end
    $finish;
  end

endmodule
